/* sv/rbs_pkg.sv */
// Shared types and constants for the RGB 3x3 box smoothing filter.
`default_nettype none

package rbs_pkg;

    // Stream field widths
    localparam int FIELD_W    = 16;
    localparam int TDATA_W    = 3 * FIELD_W;
    localparam int SIZE_W     = 11;
    localparam int RESET_SIZE = 1024;

    // Request kinds carried on tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Result control handed from the window stage to the mean stage
    typedef struct packed {
        logic       emit;       // a result is due for this request
        logic [2:0] row_mask;   // window rows in the neighbourhood, bit 0 = oldest row
        logic [2:0] col_mask;   // window columns in the neighbourhood, bit 0 = oldest column
        logic       frame_end;  // last result of the frame
    } rbs_ctrl_t;

endpackage

`default_nettype wire

/* sv/rbs_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module rbs_ram #(
    parameter int DATA_W = 96,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/rbs_window.sv */
// Raster position counters, line stores and the 3x3 neighbourhood window.
`default_nettype none

module rbs_window #(
    parameter int MAX_SIZE     = 1024,
    parameter int CHANNEL_BITS = 16,
    localparam int CNT_W = $clog2(MAX_SIZE + 2),
    localparam int PIX_W = 3 * CHANNEL_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire logic                   accept,
    input  wire logic                   restart,
    input  wire logic [CNT_W-1:0]       dim,
    input  wire logic [PIX_W-1:0]       pix_in,
    output logic      [8:0][PIX_W-1:0]  win,
    output rbs_pkg::rbs_ctrl_t          ctrl
);

    import rbs_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SIZE);

    // Raster position of the next request
    logic [CNT_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0]  col_ext, col_inc, dim_p1;
    rbs_ctrl_t         ctrl_next;
    logic              edge_due, mid_due;

    // Request held while its line store entry is read
    logic              s1_valid_reg;
    rbs_ctrl_t         s1_ctrl_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    // Line stores: older row in the upper half, newer row in the lower half
    logic [2*PIX_W-1:0] rd_data, wr_data;
    logic [PIX_W-1:0]   rd_older, rd_newer;

    logic [8:0][PIX_W-1:0] win_reg;
    rbs_ctrl_t             ctrl_reg;

    assign col_ext = CNT_W'(col_reg);
    assign col_inc = col_ext + CNT_W'(1);
    assign dim_p1  = dim + CNT_W'(1);

    // Next raster position; the flush row wraps back to the frame start
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (restart) begin
            row_next = '0;
            col_next = '0;
        end else if (accept) begin
            if ((col_reg == '0) && (row_reg > dim)) begin
                row_next = '0;
                col_next = '0;
            end else if (col_inc == dim) begin
                col_next = '0;
                row_next = row_reg + CNT_W'(1);
            end else begin
                col_next = col_inc[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Which result this request yields, with the border clipping.
    // Right-edge pixels of a row come out at column 0 of the row after next.
    assign edge_due = (col_reg == '0) && (row_reg >= CNT_W'(2));
    assign mid_due  = (col_reg != '0) && (row_reg != '0) && (row_reg <= dim);

    always_comb begin
        ctrl_next.emit = edge_due || mid_due;
        if (edge_due) begin
            ctrl_next.row_mask  = {row_reg <= dim, 1'b1, row_reg >= CNT_W'(3)};
            ctrl_next.col_mask  = 3'b011;
            ctrl_next.frame_end = (row_reg == dim_p1);
        end else begin
            ctrl_next.row_mask  = {row_reg < dim, 1'b1, row_reg >= CNT_W'(2)};
            ctrl_next.col_mask  = {2'b11, col_ext >= CNT_W'(2)};
            ctrl_next.frame_end = 1'b0;
        end
    end

    // Stage 1: request waits here while the line stores are read
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            s1_ctrl_reg <= ctrl_next;
            s1_pix_reg  <= pix_in;
            s1_addr_reg <= col_reg;
        end
    end

    // Newer row moves to the older half, the new pixel becomes the newer row.
    // Back-to-back use of one address only occurs across the flush-row wrap,
    // where the entry read is never part of a result.
    assign rd_older = rd_data[2*PIX_W-1:PIX_W];
    assign rd_newer = rd_data[PIX_W-1:0];
    assign wr_data  = {rd_newer, s1_pix_reg};

    rbs_ram #(
        .DATA_W (2 * PIX_W),
        .DEPTH  (MAX_SIZE)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (advance && s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data)
    );

    // Window shift: index 3*row + column, column 2 is the newest
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            win_reg <= '0;
        end else if (advance && s1_valid_reg) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[3*k]     <= win_reg[3*k + 1];
                win_reg[3*k + 1] <= win_reg[3*k + 2];
            end
            win_reg[2] <= rd_older;
            win_reg[5] <= rd_newer;
            win_reg[8] <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            ctrl_reg <= '0;
        end else if (advance) begin
            ctrl_reg <= s1_valid_reg ? s1_ctrl_reg : '0;
        end
    end

    assign win  = win_reg;
    assign ctrl = ctrl_reg;

endmodule

`default_nettype wire

/* sv/rbs_mean.sv */
// Masked neighbourhood sums and division by the pixel count (4, 6 or 9).
`default_nettype none

module rbs_mean #(
    parameter int CHANNEL_BITS = 16,
    localparam int PIX_W = 3 * CHANNEL_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           advance,
    input  wire logic [8:0][PIX_W-1:0]          win,
    input  wire rbs_pkg::rbs_ctrl_t             ctrl,
    output logic                                out_valid,
    output logic [rbs_pkg::TDATA_W-1:0]         out_data,
    output logic                                out_last
);

    import rbs_pkg::*;

    // Reciprocal scaling: exact quotients for any sum below 2**SUM_W
    localparam int SUM_W = CHANNEL_BITS + 4;
    localparam int SHIFT = SUM_W + 4;
    localparam int M_W   = SHIFT - 1;
    localparam int P_W   = SUM_W + M_W;
    localparam logic [M_W-1:0] RECIP4 = M_W'((64'd1 << SHIFT) / 4);
    localparam logic [M_W-1:0] RECIP6 = M_W'(((64'd1 << SHIFT) + 5) / 6);
    localparam logic [M_W-1:0] RECIP9 = M_W'(((64'd1 << SHIFT) + 8) / 9);

    logic [2:0][SUM_W-1:0] sum_next, sum_reg;
    logic [M_W-1:0]        recip_next, recip_reg;
    logic                  sum_valid_reg, sum_last_reg;
    logic [2:0][P_W-1:0]   prod;
    logic [TDATA_W-1:0]    out_data_next, out_data_reg;
    logic                  out_valid_reg, out_last_reg;

    // Sum of the pixels inside the clipped neighbourhood, per channel
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum_next[ch] = '0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    if (ctrl.row_mask[k] && ctrl.col_mask[j]) begin
                        sum_next[ch] = sum_next[ch]
                            + SUM_W'(win[3*k + j][ch*CHANNEL_BITS +: CHANNEL_BITS]);
                    end
                end
            end
        end
    end

    // Reciprocal of the pixel count
    always_comb begin
        if ((&ctrl.row_mask) && (&ctrl.col_mask)) begin
            recip_next = RECIP9;
        end else if ((&ctrl.row_mask) || (&ctrl.col_mask)) begin
            recip_next = RECIP6;
        end else begin
            recip_next = RECIP4;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            sum_valid_reg <= 1'b0;
        end else if (advance) begin
            sum_valid_reg <= ctrl.emit;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            sum_reg      <= sum_next;
            recip_reg    <= recip_next;
            sum_last_reg <= ctrl.frame_end;
        end
    end

    // Multiply by the reciprocal and keep the integer part
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = P_W'(sum_reg[ch]) * P_W'(recip_reg);
            out_data_next[ch*FIELD_W +: FIELD_W] = FIELD_W'(prod[ch][SHIFT +: CHANNEL_BITS]);
        end
    end

    // Result register
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
            out_last_reg <= sum_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

/* sv/rgb_box_smooth_3x3.sv */
// Top level of the streaming 3x3 box smoothing filter for square RGB images.
//
// Pixels enter in raster order on the s_ channel: tdata carries red, green and
// blue, tuser[0] set marks a flush request that carries no pixel. After the
// dim*dim pixels of a frame the source sends dim+1 flush requests to drain it.
// Each result on the m_ channel is the truncated mean of the pixel's 3x3
// neighbourhood clipped at the border; tlast marks the last pixel of the frame.
// A result belongs to the request one row plus one pixel after its own pixel
// and reaches the result register via the stage 1, window and sum registers.
// Unstalled throughput is one request per cycle; the line store has one read and one
// write port, and each request reads and writes its column once.
// The image size is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, which the block does not enforce. Values outside
// 2..MAX_SIZE saturate, and a write restarts the frame. Reset restores size 1024
// (saturated to MAX_SIZE) and the frame start; the line stores are not cleared and
// need no clearing pass. When m_tready is low with a result waiting, the whole
// pipeline holds and s_tready drops until the result is taken.
`default_nettype none

module rgb_box_smooth_3x3 #(
    parameter int MAX_SIZE     = 1024,
    parameter int CHANNEL_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration: image size
    input  wire logic                          cfg_wr_en,
    input  wire logic [rbs_pkg::SIZE_W-1:0]    cfg_wr_data,
    // input requests
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [rbs_pkg::TDATA_W-1:0]   s_tdata,   // red_in, green_in, blue_in
    input  wire logic                          s_tuser,   // command
    // results
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [rbs_pkg::TDATA_W-1:0]        m_tdata,   // red_out, green_out, blue_out
    output logic                               m_tlast    // frame_end
);

    import rbs_pkg::*;

    localparam int CNT_W     = $clog2(MAX_SIZE + 2);
    localparam int PIX_W     = 3 * CHANNEL_BITS;
    localparam int RESET_DIM = (RESET_SIZE > MAX_SIZE) ? MAX_SIZE : RESET_SIZE;

    logic              advance, accept;
    logic [CNT_W-1:0]  dim_reg, dim_next;
    logic [PIX_W-1:0]  pix_in;
    logic [8:0][PIX_W-1:0] win;
    rbs_ctrl_t         ctrl;

    // Pipeline moves whenever the result register is free or being emptied
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    // Image size, saturated to the supported range
    always_comb begin
        if (cfg_wr_data < SIZE_W'(2)) begin
            dim_next = CNT_W'(2);
        end else if (int'(cfg_wr_data) > MAX_SIZE) begin
            dim_next = CNT_W'(MAX_SIZE);
        end else begin
            dim_next = CNT_W'(cfg_wr_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= CNT_W'(RESET_DIM);
        end else if (cfg_wr_en) begin
            dim_reg <= dim_next;
        end
    end

    // Flush requests enter a black pixel
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            pix_in[ch*CHANNEL_BITS +: CHANNEL_BITS] = (s_tuser == CMD_FLUSH) ? '0
                : s_tdata[ch*FIELD_W +: CHANNEL_BITS];
        end
    end

    rbs_window #(
        .MAX_SIZE     (MAX_SIZE),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_window (
        .clk     (aclk),
        .rst_n   (aresetn),
        .advance (advance),
        .accept  (accept),
        .restart (cfg_wr_en),
        .dim     (dim_reg),
        .pix_in  (pix_in),
        .win     (win),
        .ctrl    (ctrl)
    );

    rbs_mean #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_mean (
        .clk       (aclk),
        .rst_n     (aresetn),
        .advance   (advance),
        .win       (win),
        .ctrl      (ctrl),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    // Saturated size always lies in the supported range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dim_reg >= CNT_W'(2)) && (int'(dim_reg) <= MAX_SIZE))
        else $error("image size register outside supported range");

    // No stale result survives reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

/* tb/tb_rgb_box_smooth_3x3.sv */
// Self-checking bench for the 3x3 box smoothing filter against a behavioural predictor.
module tb_rgb_box_smooth_3x3;
    import rbs_pkg::*;

    localparam int MAX_SIZE       = 1024;
    localparam int WHOLE_FRAME    = 1 << 30;   // cut point beyond any frame length
    localparam int SETTLE_CYCLES  = 8;         // pause that lets the pipeline registers empty after the last result
    // Longest quiet spell: an 80 % stall on either side plus a settle pause and a write
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [TDATA_W-1:0] means;     // red, green, blue from the low bits up
        logic               frame_end;
    } smooth_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [SIZE_W-1:0]    cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;

    // Predictor state
    logic [SIZE_W-1:0]    size_reg;
    logic [TDATA_W-1:0]   older_row [MAX_SIZE];
    logic [TDATA_W-1:0]   newer_row [MAX_SIZE];
    logic [TDATA_W-1:0]   win [3][3];   // [row][column], row 0 oldest, column 2 newest
    int                   in_row;
    int                   in_col;
    smooth_result_t       pending_means [$];

    int send_idle_pct;
    int recv_idle_pct;
    int sent_count;
    int result_count;
    int err_count;
    int idle_cycles;

    rgb_box_smooth_3x3 #(
        .MAX_SIZE     (MAX_SIZE),
        .CHANNEL_BITS (FIELD_W)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),    // red_in, green_in, blue_in
        .s_tuser     (s_tuser),    // command
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),    // red_out, green_out, blue_out
        .m_tlast     (m_tlast)     // frame_end
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int eff_size();
        if (size_reg < 2) return 2;
        if (size_reg > MAX_SIZE) return MAX_SIZE;
        return int'(size_reg);
    endfunction

    // Truncated mean of the window over the given rows and columns
    function automatic logic [TDATA_W-1:0] box_mean(input int rlo, input int rhi,
                                                    input int clo, input int chi);
        int unsigned        sum;
        int unsigned        count;
        int unsigned        q;
        logic [TDATA_W-1:0] res;
        count = (rhi - rlo + 1) * (chi - clo + 1);
        for (int ch = 0; ch < 3; ch++) begin
            sum = 0;
            for (int r = rlo; r <= rhi; r++) begin
                for (int c = clo; c <= chi; c++) begin
                    sum += win[r][c][ch*FIELD_W +: FIELD_W];
                end
            end
            q = sum / count;
            res[ch*FIELD_W +: FIELD_W] = q[FIELD_W-1:0];
        end
        return res;
    endfunction

    // Advance the filter by one accepted request and queue any result it releases
    task automatic smooth_step(input logic cmd, input logic [TDATA_W-1:0] data);
        int                 dim;
        int                 r;
        int                 c;
        int                 pr;
        int                 pc;
        logic [TDATA_W-1:0] pix;
        smooth_result_t     res;
        dim = eff_size();
        r   = in_row;
        c   = in_col;
        if (c >= dim) c = 0;
        pix = (cmd == CMD_FLUSH) ? '0 : data;

        // column 0: right-edge pixel of row r-2, still sitting in window columns 1..2
        if (c == 0 && r >= 2 && r - 2 < dim) begin
            pr = r - 2;
            res.means     = box_mean(pr >= 1 ? 0 : 1, pr + 1 < dim ? 2 : 1, 1, 2);
            res.frame_end = (pr == dim - 1);
            pending_means.push_back(res);
        end

        // shift the window and bring in the new column
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2]    = older_row[c];
        win[1][2]    = newer_row[c];
        win[2][2]    = pix;
        older_row[c] = newer_row[c];
        newer_row[c] = pix;

        // otherwise pixel (r-1, c-1) centred on window column 1
        if (c >= 1 && r >= 1 && r - 1 < dim) begin
            pr = r - 1;
            pc = c - 1;
            res.means     = box_mean(pr >= 1 ? 0 : 1, pr + 1 < dim ? 2 : 1,
                                     pc >= 1 ? 0 : 1, 2);
            res.frame_end = (pr == dim - 1 && pc == dim - 1);
            pending_means.push_back(res);
        end

        // raster position; wraps to the frame start after the last flush
        if (c == 0 && r >= dim + 1) begin
            in_row = 0;
            in_col = 0;
        end else begin
            c++;
            if (c >= dim) begin
                c = 0;
                r++;
            end
            in_row = r;
            in_col = c;
        end
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic logic [TDATA_W-1:0] rand_pix();
        logic [TDATA_W-1:0] p;
        for (int ch = 0; ch < 3; ch++) begin
            case ($urandom_range(0, 9))
                0:       p[ch*FIELD_W +: FIELD_W] = '0;
                1:       p[ch*FIELD_W +: FIELD_W] = '1;
                default: p[ch*FIELD_W +: FIELD_W] = FIELD_W'($urandom_range(0, 65535));
            endcase
        end
        return p;
    endfunction

    // Send one request; entered and left at a falling edge with tvalid still high
    task automatic send_req(input logic cmd, input logic [TDATA_W-1:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        smooth_step(cmd, data);
        sent_count++;
        @(negedge aclk);
    endtask

    // A frame of dim*dim pixels and dim+1 flushes, optionally cut short
    task automatic send_frame(input int dim, input int cut, input int flush_pct,
                              input int stray_pct);
        int   total;
        logic cmd;
        total = dim * dim + dim + 1;
        for (int i = 0; i < total && i < cut; i++) begin
            if (i < dim * dim)
                cmd = ($urandom_range(0, 99) < flush_pct) ? CMD_FLUSH : CMD_PIXEL;
            else
                cmd = ($urandom_range(0, 99) < stray_pct) ? CMD_PIXEL : CMD_FLUSH;
            send_req(cmd, rand_pix());
        end
    endtask

    // Stop requesting, let every expected result out, then let the pipe empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_means.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        size_reg = value;
        in_row   = 0;
        in_col   = 0;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        smooth_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (pending_means.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("result %0d unexpected: r %h g %h b %h last %b", result_count,
                             m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tlast);
            end else begin
                want = pending_means.pop_front();
                if (want.means[15:0]  !== m_tdata[15:0]  ||
                    want.means[31:16] !== m_tdata[31:16] ||
                    want.means[47:32] !== m_tdata[47:32] ||
                    want.frame_end    !== m_tlast) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("result %0d: exp r %h g %h b %h last %b got r %h g %h b %h last %b",
                                 result_count, want.means[15:0], want.means[31:16],
                                 want.means[47:32], want.frame_end, m_tdata[15:0],
                                 m_tdata[31:16], m_tdata[47:32], m_tlast);
                end
            end
        end
    end

    // Watchdog on cycles with no traffic on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL rgb_box_smooth_3x3");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // No write after reset: size comes up at its reset value
    task automatic test_reset_size();
        send_frame(RESET_SIZE, RESET_SIZE + 4, 0, 0);
    endtask

    // Full-scale and empty channels with flushes carrying junk data, then a random frame
    task automatic test_channel_extremes();
        set_size(2);
        send_req(CMD_PIXEL, 48'hFFFF_FFFF_FFFF);
        send_req(CMD_PIXEL, 48'h0000_0000_0000);
        send_req(CMD_PIXEL, 48'hFFFF_0000_FFFF);
        send_req(CMD_PIXEL, 48'h5555_AAAA_0001);
        for (int i = 0; i < 3; i++) send_req(CMD_FLUSH, '1);
        send_frame(2, WHOLE_FRAME, 0, 0);
    endtask

    // Flush in the middle of the image, pixel where a flush is due
    task automatic test_flush_and_stray();
        logic cmd;
        set_size(3);
        for (int i = 0; i < 13; i++) begin
            if (i == 4)
                cmd = CMD_FLUSH;
            else if (i == 10)
                cmd = CMD_PIXEL;
            else
                cmd = (i < 9) ? CMD_PIXEL : CMD_FLUSH;
            send_req(cmd, rand_pix());
        end
    endtask

    // Sizes below 2 and above the maximum saturate
    task automatic test_size_saturation();
        set_size(0);
        send_frame(2, WHOLE_FRAME, 0, 0);
        set_size(1);
        send_frame(2, WHOLE_FRAME, 0, 0);
        set_size(11'h7FF);
        send_frame(MAX_SIZE, 12, 0, 0);
        set_size(SIZE_W'(MAX_SIZE + 1));
        send_frame(MAX_SIZE, 12, 0, 0);
        set_size(SIZE_W'(MAX_SIZE));
        send_frame(MAX_SIZE, 6, 0, 0);
    endtask

    // A write restarts the frame; back-to-back frames wrap without a write
    task automatic test_restart_mid_frame();
        set_size(5);
        send_frame(5, 13, 0, 0);
        set_size(5);
        send_frame(5, WHOLE_FRAME, 0, 0);
        set_size(4);
        send_frame(4, 18, 0, 0);
        set_size(3);
        send_frame(3, WHOLE_FRAME, 0, 0);
        send_frame(3, WHOLE_FRAME, 10, 20);
    endtask

    // Mostly whole frames of small random size, some cut short and restarted
    task automatic test_random_frames(input int n_items);
        int stop_at;
        int dim;
        int roll;
        int cut;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
                dim = $urandom_range(2, 8);
            else if (roll < 95)
                dim = $urandom_range(9, 16);
            else
                dim = $urandom_range(17, 28);
            if (dim != eff_size() || in_row != 0 || in_col != 0 || $urandom_range(0, 7) == 0)
                set_size(SIZE_W'(dim == 2 ? $urandom_range(0, 2) : dim));
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, dim * dim + dim)
                                              : WHOLE_FRAME;
            send_frame(dim, cut, 4, 5);
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_PIXEL;
        size_reg    = RESET_SIZE;
        in_row      = 0;
        in_col      = 0;
        sent_count   = 0;
        result_count = 0;
        err_count    = 0;
        idle_cycles  = 0;
        for (int i = 0; i < MAX_SIZE; i++) begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        for (int k = 0; k < 9; k++) win[k / 3][k % 3] = '0;
        send_idle_pct = 8;
        recv_idle_pct = 80;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_size();
        test_channel_extremes();
        test_flush_and_stray();
        test_size_saturation();
        test_restart_mid_frame();
        test_random_frames(240);
        send_idle_pct = 80;
        recv_idle_pct = 8;
        test_random_frames(240);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(240);

        settle();
        if (err_count == 0 && pending_means.size() == 0) begin
            $display("PASS rgb_box_smooth_3x3");
        end else begin
            $display("FAIL rgb_box_smooth_3x3");
        end
        $finish;
    end

endmodule
